// ===== hw/rtl/pbd_pkg.sv =====
// Shared types and constants for the PackBits scanline decoder.
// Used by the front queue, the decode back end, the result queue and the top level.
package pbd_pkg;

    // Row length above row_bytes plus this slack is a format error
    localparam int unsigned LENGTH_SLACK = 80;

    // row_bytes above this value gives a two-byte row length
    localparam logic [14:0] LONG_LEN_ROW_BYTES = 15'd250;
    // row_bytes below this value selects raw rows
    localparam logic [14:0] RAW_ROW_LIMIT = 15'd8;
    // column counter saturation value
    localparam logic [15:0] COLUMN_SAT = 16'hFFFF;
    // repeat length is 257 minus the control byte
    localparam logic [8:0] RUN_BASE = 9'd257;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_BYTES    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_LEN_LO,
        PH_CTRL,
        PH_REP,
        PH_LIT
    } t_phase;

    // input word after classification
    typedef struct packed {
        logic [7:0] data;
        logic       is_run;
        logic [7:0] pkt_len;
    } t_byte_info;

    // front queue to back end
    typedef struct packed {
        logic       valid;
        t_byte_info info;
    } t_front_out;

    typedef struct packed {
        logic [7:0]  pixel_index;
        logic [14:0] start_x;
        logic [7:0]  pixel_count;
        logic [14:0] row_number;
        logic        row_end;
        logic        image_end;
        logic        bad_format;
    } t_result;

endpackage

// ===== hw/rtl/pbd_front.sv =====
// Front end: two-entry input queue that classifies each data word as it enters.
// Depends on pbd_pkg for the classified word type.
module pbd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_data_byte,
    output logic                o_full,
    output pbd_pkg::t_front_out o_front,
    input  logic                i_take
);

    pbd_pkg::t_byte_info r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic [1:0]          n_count;
    pbd_pkg::t_byte_info w_info;
    logic                w_push;
    logic                w_pop;

    // a control byte with the top bit set opens a run, else a literal
    always_comb begin
        w_info.data    = i_data_byte;
        w_info.is_run  = i_data_byte[7];
        w_info.pkt_len = i_data_byte[7] ? 8'(pbd_pkg::RUN_BASE - {1'b0, i_data_byte})
                                        : i_data_byte + 8'd1;
    end

    assign o_full         = (r_count == 2'd2);
    assign w_push         = i_push && !o_full;
    assign w_pop          = i_take && (r_count != 2'd0);
    assign o_front.valid  = (r_count != 2'd0);
    assign o_front.info   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_info;
        end
    end

endmodule

// ===== hw/rtl/pbd_back.sv =====
// Back end: configuration registers and the row/packet decode state machine.
// Takes one word a cycle while the result queue has room; depends on pbd_pkg.
module pbd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [14:0]         i_cfg_data,
    input  pbd_pkg::t_front_out i_front,
    input  logic                i_room,
    output logic                o_take,
    output logic                o_res_push,
    output pbd_pkg::t_result    o_res
);

    logic [14:0]      r_row_bytes;
    logic [14:0]      r_image_width;
    logic [14:0]      r_image_height;

    pbd_pkg::t_phase  r_phase,          n_phase;
    logic [15:0]      r_line_length,    n_line_length;
    logic [15:0]      r_bytes_consumed, n_bytes_consumed;
    logic [7:0]       r_packet_remaining, n_packet_remaining;
    logic [7:0]       r_repeat_count,   n_repeat_count;
    logic [15:0]      r_column,         n_column;
    logic [15:0]      r_current_row,    n_current_row;
    logic             r_halted,         n_halted;

    pbd_pkg::t_byte_info w_info;
    logic             w_active;
    logic             w_raw;
    logic             w_long_len;
    logic [15:0]      w_bc_inc;
    logic             w_raw_end;
    logic             w_pkt_end;
    logic [15:0]      w_row_inc;
    logic             w_img_done;
    logic [7:0]       w_place_n;
    logic             w_in_width;
    logic [15:0]      w_avail;
    logic [7:0]       w_cnt;
    logic [14:0]      w_sx;
    logic [16:0]      w_col_sum;
    logic [15:0]      w_col_next;
    logic [15:0]      w_len_value;
    logic             w_bad_len;
    logic [7:0]       w_pkt_dec;
    logic             w_finish;
    logic             w_res_valid;

    assign w_info = i_front.info;
    assign o_take = i_front.valid && i_room;

    // shared datapath: counters, column placement with clipping, length checks
    always_comb begin
        w_active   = !r_halted && (r_current_row < {1'b0, r_image_height});
        w_raw      = (r_row_bytes < pbd_pkg::RAW_ROW_LIMIT);
        w_long_len = (r_row_bytes > pbd_pkg::LONG_LEN_ROW_BYTES);
        w_bc_inc   = r_bytes_consumed + 16'd1;
        w_raw_end  = (w_bc_inc >= {1'b0, r_row_bytes});
        w_pkt_end  = (w_bc_inc >= r_line_length);
        w_row_inc  = r_current_row + 16'd1;
        w_img_done = (w_row_inc >= {1'b0, r_image_height});
        w_place_n  = (!w_raw && (r_phase == pbd_pkg::PH_REP)) ? r_repeat_count : 8'd1;
        w_in_width = (r_column < {1'b0, r_image_width});
        w_avail    = {1'b0, r_image_width} - r_column;
        if (w_in_width) begin
            w_cnt = ({8'd0, w_place_n} < w_avail) ? w_place_n : w_avail[7:0];
            w_sx  = r_column[14:0];
        end else begin
            w_cnt = 8'd0;
            w_sx  = 15'd0;
        end
        w_col_sum   = {1'b0, r_column} + {9'd0, w_place_n};
        w_col_next  = w_col_sum[16] ? pbd_pkg::COLUMN_SAT : w_col_sum[15:0];
        w_len_value = (r_phase == pbd_pkg::PH_LEN_LO) ? (r_line_length | {8'd0, w_info.data})
                                                      : {8'd0, w_info.data};
        w_bad_len   = ({1'b0, w_len_value} >
                       ({2'b0, r_row_bytes} + 17'(pbd_pkg::LENGTH_SLACK)));
        w_pkt_dec   = (r_packet_remaining != 8'd0) ? r_packet_remaining - 8'd1 : 8'd0;
    end

    // next state
    always_comb begin
        n_phase            = r_phase;
        n_line_length      = r_line_length;
        n_bytes_consumed   = r_bytes_consumed;
        n_packet_remaining = r_packet_remaining;
        n_repeat_count     = r_repeat_count;
        n_column           = r_column;
        n_current_row      = r_current_row;
        n_halted           = r_halted;
        w_finish           = 1'b0;
        if (w_active && w_raw) begin
            if (r_row_bytes != 15'd0) begin
                n_column         = w_col_next;
                n_bytes_consumed = w_bc_inc;
                w_finish         = w_raw_end;
            end
        end else if (w_active) begin
            unique case (r_phase)
                pbd_pkg::PH_CTRL: begin
                    n_bytes_consumed = w_bc_inc;
                    if (w_info.is_run) begin
                        n_repeat_count = w_info.pkt_len;
                        n_phase        = pbd_pkg::PH_REP;
                    end else begin
                        n_packet_remaining = w_info.pkt_len;
                        n_phase            = pbd_pkg::PH_LIT;
                    end
                    w_finish = w_pkt_end;
                end
                pbd_pkg::PH_REP: begin
                    n_bytes_consumed = w_bc_inc;
                    n_column         = w_col_next;
                    n_phase          = pbd_pkg::PH_CTRL;
                    w_finish         = w_pkt_end;
                end
                pbd_pkg::PH_LIT: begin
                    n_bytes_consumed   = w_bc_inc;
                    n_column           = w_col_next;
                    n_packet_remaining = w_pkt_dec;
                    if (w_pkt_dec == 8'd0) begin
                        n_phase = pbd_pkg::PH_CTRL;
                    end
                    w_finish = w_pkt_end;
                end
                default: begin
                    if ((r_phase != pbd_pkg::PH_LEN_LO) && w_long_len) begin
                        n_line_length = {w_info.data, 8'd0};
                        n_phase       = pbd_pkg::PH_LEN_LO;
                    end else begin
                        n_line_length = w_len_value;
                        if (w_bad_len) begin
                            n_halted = 1'b1;
                        end else if (w_len_value == 16'd0) begin
                            w_finish = 1'b1;
                        end else begin
                            n_bytes_consumed = 16'd0;
                            n_column         = 16'd0;
                            n_phase          = pbd_pkg::PH_CTRL;
                        end
                    end
                end
            endcase
        end
        // close the row: clear row counters and wait for the next length
        if (w_finish) begin
            n_column           = 16'd0;
            n_bytes_consumed   = 16'd0;
            n_line_length      = 16'd0;
            n_packet_remaining = 8'd0;
            n_repeat_count     = 8'd0;
            n_phase            = pbd_pkg::PH_LEN;
            n_current_row      = w_row_inc;
        end
    end

    // result word
    always_comb begin
        w_res_valid       = 1'b0;
        o_res.pixel_index = 8'd0;
        o_res.start_x     = 15'd0;
        o_res.pixel_count = 8'd0;
        o_res.row_number  = r_current_row[14:0];
        o_res.row_end     = 1'b0;
        o_res.image_end   = 1'b0;
        o_res.bad_format  = 1'b0;
        if (w_active && w_raw) begin
            if (r_row_bytes != 15'd0) begin
                w_res_valid       = (w_cnt != 8'd0) || w_raw_end;
                o_res.pixel_index = w_info.data;
                o_res.start_x     = w_sx;
                o_res.pixel_count = w_cnt;
                o_res.row_end     = w_raw_end;
                o_res.image_end   = w_raw_end && w_img_done;
            end
        end else if (w_active) begin
            unique case (r_phase)
                pbd_pkg::PH_CTRL: begin
                    w_res_valid     = w_pkt_end;
                    o_res.row_end   = 1'b1;
                    o_res.image_end = w_img_done;
                end
                pbd_pkg::PH_REP, pbd_pkg::PH_LIT: begin
                    w_res_valid       = (w_cnt != 8'd0) || w_pkt_end;
                    o_res.pixel_index = w_info.data;
                    o_res.start_x     = w_sx;
                    o_res.pixel_count = w_cnt;
                    o_res.row_end     = w_pkt_end;
                    o_res.image_end   = w_pkt_end && w_img_done;
                end
                default: begin
                    if (!((r_phase != pbd_pkg::PH_LEN_LO) && w_long_len)) begin
                        if (w_bad_len) begin
                            w_res_valid      = 1'b1;
                            o_res.bad_format = 1'b1;
                        end else if (w_len_value == 16'd0) begin
                            w_res_valid     = 1'b1;
                            o_res.row_end   = 1'b1;
                            o_res.image_end = w_img_done;
                        end
                    end
                end
            endcase
        end
    end

    assign o_res_push = o_take && w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes        <= 15'd0;
            r_image_width      <= 15'd0;
            r_image_height     <= 15'd0;
            r_phase            <= pbd_pkg::PH_LEN;
            r_line_length      <= 16'd0;
            r_bytes_consumed   <= 16'd0;
            r_packet_remaining <= 8'd0;
            r_repeat_count     <= 8'd0;
            r_column           <= 16'd0;
            r_current_row      <= 16'd0;
            r_halted           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == pbd_pkg::CFG_ROW_BYTES) begin
                    r_row_bytes <= i_cfg_data;
                end
                if (i_cfg_index == pbd_pkg::CFG_IMAGE_WIDTH) begin
                    r_image_width <= i_cfg_data;
                end
                if (i_cfg_index == pbd_pkg::CFG_IMAGE_HEIGHT) begin
                    r_image_height <= i_cfg_data;
                end
            end
            if (o_take) begin
                r_phase            <= n_phase;
                r_line_length      <= n_line_length;
                r_bytes_consumed   <= n_bytes_consumed;
                r_packet_remaining <= n_packet_remaining;
                r_repeat_count     <= n_repeat_count;
                r_column           <= n_column;
                r_current_row      <= n_current_row;
                r_halted           <= n_halted;
            end
        end
    end

endmodule

// ===== hw/rtl/pbd_res_queue.sv =====
// Two-entry result queue between the decode back end and the output ports.
// Depends on pbd_pkg for the result word type.
module pbd_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pbd_pkg::t_result i_res,
    output logic             o_room,
    output logic             o_empty,
    input  logic             i_pop,
    output pbd_pkg::t_result o_res
);

    pbd_pkg::t_result r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_pop;

    assign o_empty = (r_count == 2'd0);
    assign w_pop   = i_pop && !o_empty;
    // a pop in the same cycle frees a slot for a full queue
    assign o_room  = (r_count != 2'd2) || w_pop;
    assign o_res   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ===== hw/rtl/packbits_scanline_decoder.sv =====
// PackBits scanline decoder top: input queue, decode back end, result queue.
// Accepted words are queued, then decoded; results are queued again for the ports.
// Throughput: one word per cycle while the result queue has room; counters step per word.
// Bytes that write nothing, close no row and flag no format error give no result word.
// Reset (synchronous, active low) empties both queues, zeroes the registers and the
// decode state; the block takes words in the cycle after reset is released.
module packbits_scanline_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_pixel_index,
    output logic [14:0] o_start_x,
    output logic [7:0]  o_pixel_count,
    output logic [14:0] o_row_number,
    output logic        o_row_end,
    output logic        o_image_end,
    output logic        o_bad_format,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    pbd_pkg::t_front_out w_front;
    logic                w_take;
    logic                w_room;
    logic                w_res_push;
    pbd_pkg::t_result    w_res_in;
    pbd_pkg::t_result    w_res_out;

    pbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .o_front     (w_front),
        .i_take      (w_take)
    );

    pbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_front     (w_front),
        .i_room      (w_room),
        .o_take      (w_take),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    pbd_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_room  (w_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_res_out)
    );

    assign o_pixel_index = w_res_out.pixel_index;
    assign o_start_x     = w_res_out.start_x;
    assign o_pixel_count = w_res_out.pixel_count;
    assign o_row_number  = w_res_out.row_number;
    assign o_row_end     = w_res_out.row_end;
    assign o_image_end   = w_res_out.image_end;
    assign o_bad_format  = w_res_out.bad_format;

endmodule

// ===== test/packbits_scanline_decoder_test.sv =====
// Self-checking testbench for the PackBits scanline decoder top level.
// Drives bytes through the push/full queue port, predicts every run word in step with
// acceptance and checks the popped words in order; depends on the top and pbd_pkg.
`timescale 1ns / 1ps

module packbits_scanline_decoder_test;

    localparam int unsigned DRAIN_CYCLES  = 6;
    localparam int unsigned PRESSURE_HOLD = 300;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned MAX_REPORTS   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_pixel_index;
    logic [14:0] o_start_x;
    logic [7:0]  o_pixel_count;
    logic [14:0] o_row_number;
    logic        o_row_end;
    logic        o_image_end;
    logic        o_bad_format;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = pbd_pkg::CFG_ROW_BYTES;
    logic [14:0] i_cfg_data = 15'd0;

    packbits_scanline_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_index (o_pixel_index),
        .o_start_x     (o_start_x),
        .o_pixel_count (o_pixel_count),
        .o_row_number  (o_row_number),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end),
        .o_bad_format  (o_bad_format),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // decoder geometry as last written
    logic [14:0] geo_row_bytes = '0;
    logic [14:0] geo_width = '0;
    logic [14:0] geo_height = '0;

    // predicted decoder state
    pbd_pkg::t_phase dec_phase = pbd_pkg::PH_LEN;
    logic [15:0] row_len = '0;
    logic [15:0] row_pos = '0;
    logic [7:0]  lit_left = '0;
    logic [7:0]  run_pixels = '0;
    int unsigned col_pos = 0;
    logic [15:0] row_idx = '0;
    bit          dec_halted = 1'b0;

    pbd_pkg::t_result pending_runs[$];

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned hold_ticket = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned runs_seen = 0;
    int unsigned rows_seen = 0;
    int unsigned geo_changes = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    // ---------------------------------------------------------------- prediction

    // place n pixels at the current column, clip to the width, advance the column
    function automatic logic [7:0] clip_run(input int unsigned n, output logic [14:0] sx);
        int unsigned kept;
        kept = 0;
        sx = '0;
        if (col_pos < geo_width) begin
            kept = (n < geo_width - col_pos) ? n : geo_width - col_pos;
            sx = col_pos[14:0];
        end
        col_pos = col_pos + n;
        if (col_pos > pbd_pkg::COLUMN_SAT) col_pos = {16'd0, pbd_pkg::COLUMN_SAT};
        return kept[7:0];
    endfunction

    // close the scanline; true when the picture is complete
    function automatic bit close_row();
        col_pos = 0;
        row_pos = '0;
        row_len = '0;
        lit_left = '0;
        run_pixels = '0;
        dec_phase = pbd_pkg::PH_LEN;
        row_idx = row_idx + 16'd1;
        return row_idx >= {1'b0, geo_height};
    endfunction

    function automatic void note_run(input logic [7:0] pix, input logic [14:0] sx,
                                     input logic [7:0] cnt, input logic [14:0] row,
                                     input bit rend, input bit iend, input bit bad);
        pbd_pkg::t_result r;
        r.pixel_index = pix;
        r.start_x = sx;
        r.pixel_count = cnt;
        r.row_number = row;
        r.row_end = rend;
        r.image_end = iend;
        r.bad_format = bad;
        pending_runs = {pending_runs, r};
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0]  cnt;
        logic [14:0] sx;
        logic [14:0] row;
        bit          done;
        bit          last;
        cnt = '0;
        sx = '0;
        row = row_idx[14:0];
        done = 1'b0;
        last = 1'b0;
        if (dec_halted || row_idx >= {1'b0, geo_height}) return;
        if (geo_row_bytes < pbd_pkg::RAW_ROW_LIMIT) begin
            if (geo_row_bytes == 0) return;
            cnt = clip_run(1, sx);
            row_pos = row_pos + 16'd1;
            done = row_pos >= {1'b0, geo_row_bytes};
            if (done) last = close_row();
            if (cnt != 0 || done) note_run(b, sx, cnt, row, done, last, 1'b0);
            return;
        end
        case (dec_phase)
            pbd_pkg::PH_CTRL: begin
                row_pos = row_pos + 16'd1;
                if (b[7]) begin
                    run_pixels = 8'(pbd_pkg::RUN_BASE - {1'b0, b});
                    dec_phase = pbd_pkg::PH_REP;
                end else begin
                    lit_left = b + 8'd1;
                    dec_phase = pbd_pkg::PH_LIT;
                end
                // control byte at the row limit: the packet is cut off
                if (row_pos >= row_len) begin
                    last = close_row();
                    note_run('0, '0, '0, row, 1'b1, last, 1'b0);
                end
            end
            pbd_pkg::PH_REP: begin
                row_pos = row_pos + 16'd1;
                cnt = clip_run(32'(run_pixels), sx);
                dec_phase = pbd_pkg::PH_CTRL;
                done = row_pos >= row_len;
                if (done) last = close_row();
                if (cnt != 0 || done) note_run(b, sx, cnt, row, done, last, 1'b0);
            end
            pbd_pkg::PH_LIT: begin
                row_pos = row_pos + 16'd1;
                cnt = clip_run(1, sx);
                if (lit_left != 0) lit_left = lit_left - 8'd1;
                if (lit_left == 0) dec_phase = pbd_pkg::PH_CTRL;
                done = row_pos >= row_len;
                if (done) last = close_row();
                if (cnt != 0 || done) note_run(b, sx, cnt, row, done, last, 1'b0);
            end
            default: begin
                if (dec_phase != pbd_pkg::PH_LEN_LO &&
                    geo_row_bytes > pbd_pkg::LONG_LEN_ROW_BYTES) begin
                    row_len = {b, 8'h00};
                    dec_phase = pbd_pkg::PH_LEN_LO;
                end else begin
                    row_len = (dec_phase == pbd_pkg::PH_LEN_LO) ? (row_len | {8'h00, b})
                                                                : {8'h00, b};
                    if (row_len > geo_row_bytes + pbd_pkg::LENGTH_SLACK) begin
                        dec_halted = 1'b1;
                        note_run('0, '0, '0, row, 1'b0, 1'b0, 1'b1);
                    end else if (row_len == 0) begin
                        last = close_row();
                        note_run('0, '0, '0, row, 1'b1, last, 1'b0);
                    end else begin
                        row_pos = '0;
                        col_pos = 0;
                        dec_phase = pbd_pkg::PH_CTRL;
                    end
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------- drivers

    // offer one word at a falling edge, hold it until taken; returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        i_data_byte = b;
        push = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // stop offering, let every predicted word drain, then allow for words in flight
    task automatic wait_drained();
        push = 1'b0;
        while (pending_runs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [14:0] rb, input logic [14:0] w,
                                input logic [14:0] h);
        i_cfg_we = 1'b1;
        i_cfg_index = pbd_pkg::CFG_ROW_BYTES;
        i_cfg_data = rb;
        @(negedge i_clk);
        i_cfg_index = pbd_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data = w;
        @(negedge i_clk);
        i_cfg_index = pbd_pkg::CFG_IMAGE_HEIGHT;
        i_cfg_data = h;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        geo_row_bytes = rb;
        geo_width = w;
        geo_height = h;
        geo_changes++;
    endtask

    task automatic send_raw_row();
        repeat (geo_row_bytes) send_byte(8'($urandom_range(255)));
    endtask

    // length header then packets filling exactly len bytes; ragged rows carry noise
    task automatic send_packed_row(input int unsigned len, input bit ragged);
        int unsigned left;
        int unsigned cap;
        int unsigned k;
        if (geo_row_bytes > pbd_pkg::LONG_LEN_ROW_BYTES) send_byte(len[15:8]);
        send_byte(len[7:0]);
        left = len;
        while (left > 0) begin
            if (ragged || left == 1) begin
                send_byte(8'($urandom_range(255)));
                left--;
            end else if ($urandom_range(1) == 1) begin
                send_byte(8'($urandom_range(255, 128)));
                send_byte(8'($urandom_range(255)));
                left -= 2;
            end else begin
                cap = ($urandom_range(3) == 0) ? 128 : 6;
                if (cap > left - 1) cap = left - 1;
                k = $urandom_range(cap, 1);
                send_byte(8'(k - 1));
                repeat (k) send_byte(8'($urandom_range(255)));
                left -= k + 1;
            end
        end
    endtask

    function automatic logic [14:0] pick_width();
        case ($urandom_range(9))
            0:       return 15'd0;
            1, 2:    return 15'd32767;
            3, 4, 5: return 15'($urandom_range(20, 1));
            default: return 15'($urandom_range(200, 1));
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    always @(negedge i_clk) begin
        if (hold_ticket != hold_taken) begin
            hold_taken = hold_ticket;
            hold_left = PRESSURE_HOLD;
        end
        if (hold_left != 0) begin
            pop = 1'b0;
            hold_left--;
        end else begin
            pop = i_rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        pbd_pkg::t_result want;
        pbd_pkg::t_result got;
        if (i_rst_n && pop && !empty) begin
            got.pixel_index = o_pixel_index;
            got.start_x = o_start_x;
            got.pixel_count = o_pixel_count;
            got.row_number = o_row_number;
            got.row_end = o_row_end;
            got.image_end = o_image_end;
            got.bad_format = o_bad_format;
            runs_seen++;
            if (o_row_end) rows_seen++;
            if (pending_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected idx=%h x=%0d n=%0d row=%0d re=%b ie=%b bad=%b",
                             $realtime, got.pixel_index, got.start_x, got.pixel_count,
                             got.row_number, got.row_end, got.image_end, got.bad_format);
            end else begin
                want = pending_runs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected idx=%h x=%0d n=%0d row=%0d re=%b ie=%b bad=%b",
                                 $realtime, want.pixel_index, want.start_x, want.pixel_count,
                                 want.row_number, want.row_end, want.image_end,
                                 want.bad_format);
                        $display("%0t:   actual idx=%h x=%0d n=%0d row=%0d re=%b ie=%b bad=%b",
                                 $realtime, got.pixel_index, got.start_x, got.pixel_count,
                                 got.row_number, got.row_end, got.image_end, got.bad_format);
                    end
                end
            end
        end
    end

    // count cycles in which neither port moves a word
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_raw_rows();
        set_geometry(15'd0, 15'd32767, 15'd32767);
        // zero raw row size: bytes are dropped
        send_byte(8'h5A);
        send_byte(8'hA5);
        wait_drained();
        set_geometry(15'd1, 15'd32767, 15'd32767);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_drained();
        set_geometry(15'd7, 15'd3, 15'd32767);
        send_raw_row();
        wait_drained();
    endtask

    task automatic test_packed_rows();
        set_geometry(15'd8, 15'd32767, 15'd32767);
        send_byte(8'h00);
        send_byte(8'h04);
        send_byte(8'h81);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'h55);
        // longest and shortest runs, then a literal control cut off by the length
        send_byte(8'h05);
        send_byte(8'h80);
        send_byte(8'h0F);
        send_byte(8'hFF);
        send_byte(8'hF0);
        send_byte(8'h7F);
        // literal of three truncated after two bytes
        send_byte(8'h03);
        send_byte(8'h02);
        send_byte(8'h11);
        send_byte(8'h22);
        // repeat whose value byte lies past the row
        send_byte(8'h01);
        send_byte(8'h85);
        wait_drained();
        set_geometry(15'd251, 15'd32767, 15'd32767);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFE);
        send_byte(8'h77);
        send_byte(8'h00);
        send_byte(8'h00);
        wait_drained();
        set_geometry(15'd250, 15'd32767, 15'd32767);
        send_byte(8'h02);
        send_byte(8'hFD);
        send_byte(8'h44);
        wait_drained();
    endtask

    task automatic test_clip_and_picture_end();
        set_geometry(15'd8, 15'd0, 15'd32767);
        send_byte(8'h02);
        send_byte(8'h81);
        send_byte(8'h99);
        wait_drained();
        set_geometry(15'd8, 15'd5, 15'd32767);
        send_byte(8'h04);
        send_byte(8'h81);
        send_byte(8'h12);
        send_byte(8'h00);
        send_byte(8'h34);
        wait_drained();
        // next row is the last one; later bytes are dropped
        set_geometry(15'd8, 15'd32767, 15'(row_idx + 16'd1));
        send_byte(8'h02);
        send_byte(8'h81);
        send_byte(8'h33);
        send_byte(8'h02);
        send_byte(8'h81);
        wait_drained();
        set_geometry(15'd8, 15'd32767, 15'd0);
        send_byte(8'h00);
        wait_drained();
    endtask

    task automatic test_random_mix(input int unsigned s_pct, input int unsigned r_pct,
                                   input int unsigned n_items);
        int unsigned start;
        int unsigned rb;
        int unsigned limit;
        int unsigned len;
        send_idle = s_pct;
        recv_idle = r_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            wait_drained();
            if ($urandom_range(99) < 15) begin
                set_geometry(15'($urandom_range(7, 1)), pick_width(), 15'd32767);
                repeat ($urandom_range(10, 2)) send_raw_row();
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: rb = $urandom_range(40, 8);
                    6:                rb = 8;
                    7:                rb = $urandom_range(250, 41);
                    8:                rb = $urandom_range(400, 251);
                    default:          rb = 32767;
                endcase
                set_geometry(15'(rb), pick_width(), 15'd32767);
                limit = rb + pbd_pkg::LENGTH_SLACK;
                if (limit > 120) limit = 120;
                repeat ($urandom_range(6, 2)) begin
                    case ($urandom_range(19))
                        0:       len = 0;
                        1:       len = limit;
                        default: len = $urandom_range(limit < 24 ? limit : 24, 1);
                    endcase
                    send_packed_row(len, $urandom_range(3) == 0);
                end
            end
        end
        wait_drained();
    endtask

    // stop popping for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        set_geometry(15'd1, 15'd32767, 15'd32767);
        hold_ticket++;
        repeat (64) send_byte(8'($urandom_range(255)));
        wait_drained();
    endtask

    // one long row of maximum repeats drives the column counter into saturation
    task automatic test_column_saturation();
        set_geometry(15'd1000, 15'd32767, 15'd32767);
        send_byte(8'h03);
        send_byte(8'hFA);
        repeat (509) begin
            send_byte(8'h80);
            send_byte(8'($urandom_range(255)));
        end
        wait_drained();
    endtask

    // length one above the slack halts the decoder for good
    task automatic test_bad_length();
        set_geometry(15'd32767, 15'd32767, 15'd32767);
        send_byte(8'h80);
        send_byte(8'h50);
        send_byte(8'h00);
        send_byte(8'h00);
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        send_idle = 11;
        recv_idle = 54;
        test_raw_rows();
        test_packed_rows();
        test_clip_and_picture_end();
        test_random_mix(11, 54, 200);
        test_random_mix(54, 11, 200);
        test_random_mix(0, 0, 200);
        send_idle = 0;
        recv_idle = 0;
        test_backpressure();
        test_column_saturation();
        test_bad_length();
        mismatches += pending_runs.size();
        $display("Decoded %0d bytes into %0d run words over %0d scanlines, %0d geometry settings,",
                 bytes_sent, runs_seen, rows_seen, geo_changes);
        $display("raw and packed rows, clipping, picture end and a halting bad row length.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_front.sv
hw/rtl/pbd_back.sv
hw/rtl/pbd_res_queue.sv
hw/rtl/packbits_scanline_decoder.sv
test/packbits_scanline_decoder_test.sv
